// ===== hdl/indexed_sequence_store_unit_assert.svh =====
// ----------------------------------------------------------------------------
// indexed sequence store assertion macros
// concurrent checks on the clk domain, masked while rst_n is low
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_STORE_UNIT_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_UNIT_ASSERT_SVH

// condition holds at every clock edge
`define ISU_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("isu invariant violated");

// consequent holds in the same cycle as the trigger
`define ISU_ASSERT_IMPL(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("isu same-cycle check failed");

// consequent holds in the cycle after the trigger
`define ISU_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("isu next-cycle check failed");

`endif

// ===== hdl/isu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isu_pkg
// shared types and constants of the indexed sequence store
// ----------------------------------------------------------------------------
package isu_pkg;

    localparam int DW = 32;   // entry width

    typedef enum logic [2:0] {
        MODE_READ     = 3'd0,
        MODE_INS_HEAD = 3'd1,
        MODE_INS_TAIL = 3'd2,
        MODE_INS_AT   = 3'd3,
        MODE_DELETE   = 3'd4
    } mode_t;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // open a gap at slot, write value there
        logic del;   // close the gap at slot
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/isu_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isu_cell
// one entry of the chain: holds, takes from its lower or upper neighbor,
// or loads the inserted value
// ----------------------------------------------------------------------------
module isu_cell
    import isu_pkg::*;
#(
    parameter int IW    = 6,
    parameter int INDEX = 0
)
(
    input  wire logic          clk,
    input  wire cell_ctrl_t    ctrl,
    input  wire logic [IW-1:0] slot,
    input  wire logic [DW-1:0] value,
    input  wire logic [DW-1:0] prev,
    input  wire logic [DW-1:0] next,
    input  wire logic [IW-1:0] rd_slot,
    output logic      [DW-1:0] data,
    output logic      [DW-1:0] rd_term
);

    localparam logic [IW-1:0] IDX = IW'(INDEX);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (IDX == slot)
            begin
                data_next = value;
            end
            else if (IDX > slot)
            begin
                data_next = prev;
            end
        end
        else if (ctrl.del && (IDX >= slot))
        begin
            data_next = next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // leaf term of the read tree, zero unless this cell is addressed
    assign rd_term = (IDX == rd_slot) ? data_reg : '0;

endmodule
`default_nettype wire

// ===== hdl/isu_rtree.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isu_rtree
// registered or-reduction tree that gathers the addressed cell's value
// ----------------------------------------------------------------------------
module isu_rtree
    import isu_pkg::*;
#(
    parameter int NL = 64   // leaf count, a power of two
)
(
    input  wire logic               clk,
    input  wire logic [NL-1:0][DW-1:0] leaves,
    output logic      [DW-1:0]      root
);

    // heap order: node k has children 2k and 2k+1, leaves at NL .. 2NL-1
    logic [DW-1:0] tree_reg [1:2*NL-1];

    for (genvar i = 0; i < NL; i++)
    begin : g_leaf
        always_ff @(posedge clk)
        begin
            tree_reg[NL+i] <= leaves[i];
        end
    end

    for (genvar k = 1; k < NL; k++)
    begin : g_node
        always_ff @(posedge clk)
        begin
            tree_reg[k] <= tree_reg[2*k] | tree_reg[2*k+1];
        end
    end

    assign root = tree_reg[1];

endmodule
`default_nettype wire

// ===== hdl/indexed_sequence_store_unit.sv =====
`default_nettype none
`include "indexed_sequence_store_unit_assert.svh"
// ----------------------------------------------------------------------------
// indexed_sequence_store_unit
// ordered store of signed 32-bit values with read, insert and delete by index
// ----------------------------------------------------------------------------
// The store is a chain of CAPACITY cells, one entry each. Insert and delete
// move every later entry by one place in the same clock edge, so a request
// that is not a read is finished at the transfer that brings it in and its
// result is in the output register on the next cycle: one request per cycle
// while results are drained. A read goes through a registered or-tree of
// $clog2(CAPACITY) levels over the cells and keeps the block busy until its
// root is ready and the output register is free; the depth of that tree
// sets the read time. A new request is taken whenever no read is in
// flight and the output register is empty or being emptied in that cycle.
// Negative insert positions go to the head, positions above the length are
// refused with status invalid, and inserts into a full store with status full.
// ----------------------------------------------------------------------------
module indexed_sequence_store_unit
    import isu_pkg::*;
#(
    parameter int CAPACITY = 64   // 2 .. 127
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,    // position[31:0], value_in[63:32]
    input  wire logic [2:0]  s_tuser,    // mode[2:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,    // read_value[31:0], length[38:32], zero[39]
    output logic      [1:0]  m_tuser     // status[1:0]
);

    localparam int IW = $clog2(CAPACITY);       // entry index width
    localparam int CW = $clog2(CAPACITY + 1);   // length count width
    localparam int NL = 1 << IW;                // read tree leaves
    localparam int TW = $clog2(IW + 2);         // read wait counter width

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // control state
    state_t          state_reg, state_next;
    logic [TW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;
    // read request and result payload
    logic [IW-1:0]   rd_slot_reg, rd_slot_next;
    logic            rd_ok_reg, rd_ok_next;
    logic [DW-1:0]   rd_value_reg, rd_value_next;
    logic [1:0]      status_reg, status_next;
    logic [6:0]      length_reg, length_next;

    // request decode
    mode_t           mode;
    logic [31:0]     position;
    logic [DW-1:0]   value_in;
    logic [31:0]     count_ext;
    logic            accept;
    logic            out_free;
    logic            pos_neg;
    logic            pos_lt;
    logic            pos_gt;
    logic            full;
    logic            ins_req;
    logic            ins_go;
    logic            del_go;
    logic [IW-1:0]   slot;
    logic [1:0]      st;
    cell_ctrl_t      ctrl;

    // chain and read tree
    logic [DW-1:0]          cell_data [CAPACITY];
    logic [NL-1:0][DW-1:0]  leaves;
    logic [DW-1:0]          root;

    assign mode      = mode_t'(s_tuser[2:0]);
    assign position  = s_tdata[31:0];
    assign value_in  = s_tdata[63:32];
    assign count_ext = 32'(count_reg);

    // result register frees up when empty or taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign pos_neg = position[31];
    assign pos_lt  = !pos_neg && (position < count_ext);
    assign pos_gt  = !pos_neg && (position > count_ext);
    assign full    = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        ins_req = 1'b0;
        del_go  = 1'b0;
        slot    = '0;
        st      = ST_DONE;
        case (mode)
            MODE_READ:
            begin
                if (!pos_lt)
                begin
                    st = ST_INVALID;
                end
            end
            MODE_INS_HEAD:
            begin
                ins_req = 1'b1;
            end
            MODE_INS_TAIL:
            begin
                ins_req = 1'b1;
                slot    = count_reg[IW-1:0];
            end
            MODE_INS_AT:
            begin
                // past the end is refused before the full check
                if (pos_gt)
                begin
                    st = ST_INVALID;
                end
                else
                begin
                    ins_req = 1'b1;
                    slot    = pos_neg ? '0 : position[IW-1:0];
                end
            end
            MODE_DELETE:
            begin
                if (pos_lt)
                begin
                    del_go = 1'b1;
                    slot   = position[IW-1:0];
                end
                else
                begin
                    st = ST_INVALID;
                end
            end
            default:
            begin
                st = ST_INVALID;
            end
        endcase
        ins_go = 1'b0;
        if (ins_req)
        begin
            if (full)
            begin
                st = ST_FULL;
            end
            else
            begin
                ins_go = 1'b1;
            end
        end
    end

    // cells move only on a transfer that really changes the store
    assign ctrl.ins = accept && ins_go;
    assign ctrl.del = accept && del_go;

    // chain of entry cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DW-1:0] prev_w;
        logic [DW-1:0] next_w;

        if (i == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_prev
            assign prev_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_next
            assign next_w = cell_data[i+1];
        end

        isu_cell #(
            .IW    (IW),
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .slot    (slot),
            .value   (value_in),
            .prev    (prev_w),
            .next    (next_w),
            .rd_slot (rd_slot_reg),
            .data    (cell_data[i]),
            .rd_term (leaves[i])
        );
    end

    // unused tree leaves when CAPACITY is not a power of two
    for (genvar j = CAPACITY; j < NL; j++)
    begin : g_pad
        assign leaves[j] = '0;
    end

    isu_rtree #(
        .NL (NL)
    ) u_rtree (
        .clk    (clk),
        .leaves (leaves),
        .root   (root)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        rd_slot_next   = rd_slot_reg;
        rd_ok_next     = rd_ok_reg;
        rd_value_next  = rd_value_reg;
        status_next    = status_reg;
        length_next    = length_reg;

        if (ctrl.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.del)
        begin
            count_next = count_reg - 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_READ)
                    begin
                        // the leaf registers take the addressed value first, then the tree reduces it level by level
                        state_next   = S_READ;
                        cnt_next     = TW'(IW + 1);
                        rd_slot_next = position[IW-1:0];
                        rd_ok_next   = pos_lt;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        rd_value_next  = '0;
                        status_next    = st;
                        length_next    = 7'(count_next);
                    end
                end
            end
            S_READ:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    rd_value_next  = rd_ok_reg ? root : '1;
                    status_next    = rd_ok_reg ? ST_DONE : ST_INVALID;
                    length_next    = 7'(count_reg);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_slot_reg   <= '0;
            rd_ok_reg     <= 1'b0;
            rd_value_reg  <= '0;
            status_reg    <= ST_DONE;
            length_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rd_slot_reg   <= rd_slot_next;
            rd_ok_reg     <= rd_ok_next;
            rd_value_reg  <= rd_value_next;
            status_reg    <= status_next;
            length_reg    <= length_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, length_reg, rd_value_reg};
    assign m_tuser  = status_reg;

    // length never runs past the number of cells
    `ISU_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY))
    // a taken delete shortens the store by exactly one
    `ISU_ASSERT_NEXT(a_del_count, ctrl.del, count_reg == $past(count_reg) - 1'b1)
    // no new request while a read walks the tree
    `ISU_ASSERT_IMPL(a_read_busy, state_reg == S_READ, !s_tready)

endmodule
`default_nettype wire

// ===== tb/isu_scoreboard.sv =====
// ----------------------------------------------------------------------------
// isu_scoreboard
// watches both streams of the indexed sequence store, keeps a shadow copy of
// the sequence and compares every result transfer with its prediction
// ----------------------------------------------------------------------------
module isu_scoreboard
    import isu_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          errors,
    output int          pending,
    output int          len_hint,
    output int          n_requests,
    output int          n_read_hits,
    output int          n_full,
    output int          n_invalid,
    output int          peak_len
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
        logic [6:0]  length;
    } seq_result_t;

    logic [31:0] shadow [CAPACITY];
    int          fill;
    seq_result_t due_results [$];

    initial begin
        errors      = 0;
        pending     = 0;
        len_hint    = 0;
        n_requests  = 0;
        n_read_hits = 0;
        n_full      = 0;
        n_invalid   = 0;
        peak_len    = 0;
    end

    // one request against the shadow sequence, returns the result it causes
    function automatic seq_result_t apply_request(logic [2:0] mode, logic signed [31:0] pos,
                                                  logic [31:0] val);
        seq_result_t r;
        bit          do_ins;
        int          slot;
        r.read_value = '0;
        r.status     = ST_DONE;
        do_ins       = 1'b0;
        slot         = 0;
        case (mode)
            MODE_READ:
                if (pos >= 0 && pos < fill)
                    r.read_value = shadow[pos];
                else
                begin
                    r.read_value = '1;
                    r.status     = ST_INVALID;
                end
            MODE_INS_HEAD:
                do_ins = 1'b1;
            MODE_INS_TAIL:
            begin
                do_ins = 1'b1;
                slot   = fill;
            end
            MODE_INS_AT:
                // position check comes before the full check
                if (pos > fill)
                    r.status = ST_INVALID;
                else
                begin
                    do_ins = 1'b1;
                    slot   = (pos < 0) ? 0 : int'(pos);
                end
            MODE_DELETE:
                if (pos >= 0 && pos < fill)
                begin
                    for (int i = pos; i + 1 < fill; i++)
                        shadow[i] = shadow[i + 1];
                    fill--;
                end
                else
                    r.status = ST_INVALID;
            default:
                r.status = ST_INVALID;
        endcase
        if (do_ins)
        begin
            if (fill >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                for (int i = fill; i > slot; i--)
                    shadow[i] = shadow[i - 1];
                shadow[slot] = val;
                fill++;
            end
        end
        r.length = fill[6:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        seq_result_t due;
        seq_result_t seen;
        if (!rst_n)
        begin
            fill = 0;
            due_results.delete();
        end
        else
        begin
            // request first: a result never belongs to the transfer of the same edge
            if (s_tvalid && s_tready)
            begin
                due = apply_request(s_tuser, s_tdata[31:0], s_tdata[63:32]);
                due_results.push_back(due);
                n_requests <= n_requests + 1;
                if (s_tuser == MODE_READ && due.status == ST_DONE)
                    n_read_hits <= n_read_hits + 1;
                if (due.status == ST_FULL)
                    n_full <= n_full + 1;
                if (due.status == ST_INVALID)
                    n_invalid <= n_invalid + 1;
                if (fill > peak_len)
                    peak_len <= fill;
            end
            if (m_tvalid && m_tready)
            begin
                seen.read_value = m_tdata[31:0];
                seen.length     = m_tdata[38:32];
                seen.status     = m_tuser;
                if (due_results.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    errors <= errors + 1;
                end
                else
                begin
                    due = due_results.pop_front();
                    if (seen.read_value !== due.read_value)
                        $error("read_value mismatch: expected %0d, got %0d",
                               $signed(due.read_value), $signed(seen.read_value));
                    if (seen.status !== due.status)
                        $error("status mismatch: expected %0d, got %0d",
                               due.status, seen.status);
                    if (seen.length !== due.length)
                        $error("length mismatch: expected %0d, got %0d",
                               due.length, seen.length);
                    if (m_tdata[39] !== 1'b0)
                        $error("pad bit mismatch: expected 0, got %b", m_tdata[39]);
                    if (seen !== due || m_tdata[39] !== 1'b0)
                        errors <= errors + 1;
                end
            end
        end
        pending  <= due_results.size();
        len_hint <= fill;
    end

endmodule

// ===== tb/indexed_sequence_store_unit_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_store_unit_tb
// directed and random request streams against the indexed sequence store,
// with random stalls on both sides and a scoreboard that checks each result
// ----------------------------------------------------------------------------
module indexed_sequence_store_unit_tb;
    import isu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 64;
    // modes the block does not define, answered with status invalid
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 20;    // covers the read latency of the block
    localparam int PHASE_ITEMS  = 410;
    localparam int EPOCH_ITEMS  = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // position[31:0], value_in[63:32]
    logic [2:0]  s_tuser = '0;   // mode[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // read_value[31:0], length[38:32], zero[39]
    logic [1:0]  m_tuser;        // status[1:0]

    int errors;
    int pending;
    int len_hint;
    int n_requests;
    int n_read_hits;
    int n_full;
    int n_invalid;
    int peak_len;

    int tx_idle_pct = 19;
    int rx_idle_pct = 60;
    int hold_asked  = 0;   // bumped by the stimulus to ask for a hold-off
    int hold_done   = 0;
    int hold_left   = 0;
    int cycles      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    indexed_sequence_store_unit #(.CAPACITY(CAPACITY)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    isu_scoreboard #(.CAPACITY(CAPACITY)) u_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .pending     (pending),
        .len_hint    (len_hint),
        .n_requests  (n_requests),
        .n_read_hits (n_read_hits),
        .n_full      (n_full),
        .n_invalid   (n_invalid),
        .peak_len    (peak_len)
    );

    // result side: random stalls, plus a long hold-off when asked for
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_done)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= hold_done + 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic send_req(logic [2:0] mode, logic [31:0] pos, logic [31:0] val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, pos};
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // random value, extremes now and then so that the sign bit is well exercised
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // position mostly around the current length, sometimes wild
    function automatic logic [31:0] pick_position(int len);
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return -$urandom_range(1, 4);
            2:       return len;
            3:       return len + $urandom_range(1, 3);
            default: return $urandom_range(0, (len > 0) ? len - 1 : 0);
        endcase
    endfunction

    // random request; ins_pct sets how hard the stream pushes toward a full store
    task automatic random_request(int ins_pct);
        logic [2:0] mode;
        int         roll;
        roll = $urandom_range(99);
        if (roll < 3)
            mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        else if (roll < 3 + ins_pct)
            case ($urandom_range(3))
                0:       mode = MODE_INS_HEAD;
                1:       mode = MODE_INS_TAIL;
                default: mode = MODE_INS_AT;
            endcase
        else if ($urandom_range(1))
            mode = MODE_READ;
        else
            mode = MODE_DELETE;
        send_req(mode, pick_position(len_hint), pick_value());
    endtask

    // sequences of epochs that alternate between filling and draining the store
    task automatic random_phase(int items);
        for (int i = 0; i < items; i++)
            random_request(((i / EPOCH_ITEMS) % 2 == 0) ? 80 : 25);
    endtask

    // sender pauses until every outstanding result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, head and tail inserts, extreme positions,
        // middle insert and delete, out-of-range reads and deletes, spare modes
        send_req(MODE_READ, 32'd0, 32'd0);
        send_req(MODE_DELETE, 32'd0, 32'd0);
        send_req(MODE_INS_AT, 32'd1, 32'd11);             // past the end
        send_req(MODE_INS_HEAD, 32'd0, 32'h7FFF_FFFF);
        send_req(MODE_INS_TAIL, 32'd0, 32'h8000_0000);
        send_req(MODE_INS_AT, -32'sd5, 32'hFFFF_FFFF);    // negative goes to head
        send_req(MODE_INS_AT, 32'd3, 32'd0);              // equal to length: tail
        send_req(MODE_INS_AT, 32'd2, 32'h1234_5678);      // middle
        send_req(MODE_INS_AT, 32'h8000_0000, 32'hA5A5_A5A5);
        send_req(MODE_INS_AT, 32'h7FFF_FFFF, 32'd1);      // far past the end
        send_req(MODE_READ, 32'd0, 32'd0);
        send_req(MODE_READ, 32'd5, 32'd0);                // last entry
        send_req(MODE_READ, 32'd6, 32'd0);                // equal to length
        send_req(MODE_READ, -32'sd1, 32'd0);
        send_req(MODE_READ, 32'h7FFF_FFFF, 32'd0);
        send_req(MODE_READ, 32'h8000_0000, 32'd0);
        send_req(MODE_DELETE, 32'h8000_0000, 32'd0);
        send_req(MODE_DELETE, 32'd6, 32'd0);
        send_req(MODE_DELETE, 32'd2, 32'd0);              // middle
        send_req(MODE_DELETE, 32'd4, 32'd0);              // last
        send_req(MODE_DELETE, 32'd0, 32'd0);              // head
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            send_req(m[2:0], $urandom, $urandom);
        send_req(MODE_READ, 32'd1, 32'd0);
        wait_drained();

        // sender idles lightly, receiver heavily
        random_phase(PHASE_ITEMS);
        wait_drained();

        // and the other way round
        tx_idle_pct = 60;
        rx_idle_pct = 19;
        random_phase(PHASE_ITEMS);
        wait_drained();

        // no idling; open with a long receiver hold-off so the input backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_asked  = hold_asked + 1;
        random_phase(PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests in %0d cycles: %0d read hits, %0d full refusals, %0d invalid",
                 n_requests, cycles, n_read_hits, n_full, n_invalid);
        $display("peak length %0d of %0d, %0d mismatches", peak_len, CAPACITY, errors);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
